// ----- hdl/rau_pkg.sv -----
package rau_pkg;

    localparam int WIDTH_DEF = 32;

    // operation codes carried on the request tuser
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 72;

    typedef logic [2:0] t_opcode;
    typedef logic [1:0] t_status;

endpackage

// ----- hdl/rational_arith_unit.sv -----
// Channel   Dir  tdata (low bit up)                        tuser      tlast
// s_axis    in   a_num, a_den, b_num, b_den (32b each)      opcode(3)  -
// m_axis    out  res_num(32), res_den(31), lt, eq, gt, pad  status(2)  -
//
// A request passes through the multiply steps, a combine step, binary GCD
// steps, two restoring divisions on the shared divide unit (numerator and
// denominator by the GCD) and one range check. Compares stop after the
// combine step; a zero numerator skips the divisions and the range check.
// Zero-divisor and unused-opcode requests go straight to the final state.
// i_rst_n is synchronous, active low; it clears the sequencer and drops any
// pending result. A finished result sits in the output register while the
// next request is taken; the sequencer holds in its final state only when an
// earlier result still waits there.
module rational_arith_unit #(
    parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  logic [rau_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode [2:0]
    input  rau_pkg::t_opcode                s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // res_num [31:0], res_den [62:32], is_less [63], is_equal [64],
    // is_greater [65], zero pad [71:66]
    output logic [rau_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output rau_pkg::t_status                m_axis_tuser
);
    import rau_pkg::*;

    localparam int PW = 2 * WIDTH;
    localparam int CW = $clog2(PW) + 1;
    localparam logic [PW-1:0] LIM  = PW'((64'd1 << (WIDTH - 1)) - 64'd1);
    localparam logic [PW-1:0] LIM1 = PW'(64'd1 << (WIDTH - 1));
    localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_COMB = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_CHK  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]       r_state;
    t_opcode          r_op;
    logic [WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic             r_an_neg, r_ad_neg, r_bn_neg, r_bd_neg;
    logic [1:0]       r_step;
    logic [PW-1:0]    r_pa, r_pb, r_pc;
    logic             r_pa_neg, r_pb_neg, r_pc_neg;
    logic [PW-1:0]    r_nmag, r_dmag;
    logic             r_nneg;
    logic [PW-1:0]    r_u, r_v, r_g, r_dv, r_rem;
    logic [CW-1:0]    r_k, r_cnt;
    logic             r_phase;

    logic [31:0]      r_rnum;
    logic [30:0]      r_rden;
    logic             r_lt, r_eq, r_gt;
    t_status          r_st;

    logic             r_o_valid;
    logic [31:0]      r_o_num;
    logic [30:0]      r_o_den;
    logic             r_o_lt, r_o_eq, r_o_gt;
    t_status          r_o_st;

    // operand decode: low WIDTH bits, two's complement to sign/magnitude
    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic [WIDTH-1:0] mg_an, mg_ad, mg_bn, mg_bd;
    logic             accept;

    assign in_an = s_axis_tdata[WIDTH-1:0];
    assign in_ad = s_axis_tdata[32+WIDTH-1:32];
    assign in_bn = s_axis_tdata[64+WIDTH-1:64];
    assign in_bd = s_axis_tdata[96+WIDTH-1:96];
    assign mg_an = in_an[WIDTH-1] ? (~in_an + 1'b1) : in_an;
    assign mg_ad = in_ad[WIDTH-1] ? (~in_ad + 1'b1) : in_ad;
    assign mg_bn = in_bn[WIDTH-1] ? (~in_bn + 1'b1) : in_bn;
    assign mg_bd = in_bd[WIDTH-1] ? (~in_bd + 1'b1) : in_bd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // shared multiplier: operand selection per step
    logic [WIDTH-1:0] mx, my;
    logic             mx_neg, my_neg, m_flip, m_last;
    logic [PW-1:0]    prod;
    logic             prod_neg;

    always_comb begin
        mx = r_ad; mx_neg = r_ad_neg;
        my = r_bd; my_neg = r_bd_neg;
        m_flip = 1'b0;
        if (r_step == 2'd0) begin
            mx = r_an; mx_neg = r_an_neg;
            if (r_op == OP_MUL) begin
                my = r_bn; my_neg = r_bn_neg;
            end else if (r_op == OP_NEG) begin
                my = WIDTH'(1); my_neg = 1'b0;
                m_flip = 1'b1;
            end
        end else if (r_step == 2'd1) begin
            priority if (r_op == OP_MUL) begin
                mx = r_ad; mx_neg = r_ad_neg;
                my = r_bd; my_neg = r_bd_neg;
            end else if (r_op == OP_DIV) begin
                mx = r_ad; mx_neg = r_ad_neg;
                my = r_bn; my_neg = r_bn_neg;
            end else if (r_op == OP_NEG) begin
                mx = r_ad; mx_neg = r_ad_neg;
                my = WIDTH'(1); my_neg = 1'b0;
            end else begin
                mx = r_bn; mx_neg = r_bn_neg;
                my = r_ad; my_neg = r_ad_neg;
                m_flip = (r_op == OP_SUB) || (r_op == OP_CMP);
            end
        end
        prod     = PW'(mx) * PW'(my);
        prod_neg = (mx != '0) && (my != '0) && (mx_neg ^ my_neg ^ m_flip);
        m_last   = (r_step == 2'd2) ||
                   ((r_step == 2'd1) && (r_op != OP_ADD) && (r_op != OP_SUB));
    end

    // combine: signed-magnitude add of the two cross products for add, subtract and compare
    logic [PW-1:0] c_mag, c_dmag;
    logic          c_neg, c_dneg, a_ge_b;

    always_comb begin
        a_ge_b = (r_pa >= r_pb);
        if ((r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_CMP)) begin
            if (r_pa_neg == r_pb_neg) begin
                c_mag = r_pa + r_pb; c_neg = r_pa_neg;
            end else if (a_ge_b) begin
                c_mag = r_pa - r_pb; c_neg = r_pa_neg;
            end else begin
                c_mag = r_pb - r_pa; c_neg = r_pb_neg;
            end
        end else begin
            c_mag = r_pa; c_neg = r_pa_neg;
        end
        if ((r_op == OP_ADD) || (r_op == OP_SUB)) begin
            c_dmag = r_pc; c_dneg = r_pc_neg;
        end else begin
            c_dmag = r_pb; c_dneg = r_pb_neg;
        end
    end

    // restoring divide step
    logic [PW:0]   d_rs;
    logic          d_ge;
    logic [PW-1:0] d_rem, d_q;

    always_comb begin
        d_rs  = {r_rem, r_dv[PW-1]};
        d_ge  = (d_rs >= {1'b0, r_g});
        d_rem = d_ge ? PW'(d_rs - {1'b0, r_g}) : d_rs[PW-1:0];
        d_q   = {r_dv[PW-2:0], d_ge};
    end

    // final range check and sign application
    logic [PW-1:0]            f_num;
    logic signed [WIDTH-1:0]  f_low;
    logic                     f_ovf;

    always_comb begin
        f_num = r_nneg ? (~r_nmag + 1'b1) : r_nmag;
        f_low = f_num[WIDTH-1:0];
        f_ovf = (r_dmag > LIM) || (r_nneg ? (r_nmag > LIM1) : (r_nmag > LIM));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // load on a finished request, drop once the result is taken
            if ((r_state == S_FIN) && (!r_o_valid || m_axis_tready)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op     <= s_axis_tuser;
                        r_an     <= mg_an; r_an_neg <= in_an[WIDTH-1];
                        r_ad     <= mg_ad; r_ad_neg <= in_ad[WIDTH-1];
                        r_bn     <= mg_bn; r_bn_neg <= in_bn[WIDTH-1];
                        r_bd     <= mg_bd; r_bd_neg <= in_bd[WIDTH-1];
                        r_step   <= 2'd0;
                        r_rnum   <= '0; r_rden <= '0;
                        r_lt     <= 1'b0; r_eq <= 1'b0; r_gt <= 1'b0;
                        priority if (s_axis_tuser > OP_CMP) begin
                            r_st    <= ST_OK;
                            r_state <= S_FIN;
                        end else if ((mg_ad == '0) ||
                                     ((s_axis_tuser != OP_NEG) && (mg_bd == '0)) ||
                                     ((s_axis_tuser == OP_DIV) && (mg_bn == '0))) begin
                            r_st    <= ST_DIV0;
                            r_state <= S_FIN;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    unique case (r_step)
                        2'd0:    begin r_pa <= prod; r_pa_neg <= prod_neg; end
                        2'd1:    begin r_pb <= prod; r_pb_neg <= prod_neg; end
                        default: begin r_pc <= prod; r_pc_neg <= prod_neg; end
                    endcase
                    r_step <= r_step + 2'd1;
                    if (m_last) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    if (r_op == OP_CMP) begin
                        // sign of a - b, corrected for the denominators' signs
                        r_eq    <= (c_mag == '0);
                        r_lt    <= (c_mag != '0) && (c_neg != (r_ad_neg ^ r_bd_neg));
                        r_gt    <= (c_mag != '0) && (c_neg == (r_ad_neg ^ r_bd_neg));
                        r_state <= S_FIN;
                    end else begin
                        r_nmag  <= c_mag;
                        r_dmag  <= c_dmag;
                        r_nneg  <= (c_mag != '0) && (c_neg ^ c_dneg);
                        r_u     <= c_mag;
                        r_v     <= c_dmag;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    priority if (r_u == '0) begin
                        r_rnum  <= '0;
                        r_rden  <= 31'd1;
                        r_state <= S_FIN;
                    end else if (r_u == r_v) begin
                        r_g     <= r_u << r_k;
                        r_dv    <= r_nmag;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_DIV;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u > r_v) begin
                        r_u <= (r_u - r_v) >> 1;
                    end else begin
                        r_v <= (r_v - r_u) >> 1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == DIV_LAST) begin
                        if (!r_phase) begin
                            r_nmag  <= d_q;
                            r_dv    <= r_dmag;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_phase <= 1'b1;
                        end else begin
                            r_dmag  <= d_q;
                            r_state <= S_CHK;
                        end
                    end else begin
                        r_rem <= d_rem;
                        r_dv  <= d_q;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CHK: begin
                    if (f_ovf) begin
                        r_st <= ST_OVF;
                    end else begin
                        r_rnum <= 32'(f_low);
                        r_rden <= 31'(r_dmag[WIDTH-2:0]);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_num   <= r_rnum;
                        r_o_den   <= r_rden;
                        r_o_lt    <= r_lt;
                        r_o_eq    <= r_eq;
                        r_o_gt    <= r_gt;
                        r_o_st    <= r_st;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_gt, r_o_eq, r_o_lt, r_o_den, r_o_num};
    assign m_axis_tuser  = r_o_st;

endmodule

// ----- hdl/rau_checker.sv -----
module rau_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rau_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input rau_pkg::t_status                m_axis_tuser
);
    import rau_pkg::*;

    // a result never shows more than one compare flag
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[65:63]))
        else $error("more than one compare flag set");

    // an error status carries all-zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero data");

    // the block works on one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // reset drops any pending result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- test/tb_checker.sv -----
module tb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [rau_pkg::IN_DATA_W-1:0]  s_data,
    input  rau_pkg::t_opcode               s_user,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [rau_pkg::OUT_DATA_W-1:0] m_data,
    input  rau_pkg::t_status               m_user,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        lt;
        logic        eq;
        logic        gt;
        t_status     st;
    } t_fraction_result;

    t_fraction_result result_q[$];

    // magnitude/sign pair, 64-bit magnitude covers the cross products
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_smag;

    function automatic t_smag to_smag(logic [31:0] raw);
        t_smag r;
        r.neg = raw[31];
        r.mag = {32'd0, (raw[31] ? (~raw + 32'd1) : raw)};
        if (raw[31] && raw[30:0] == 0) r.mag = 64'h8000_0000;
        return r;
    endfunction

    function automatic t_smag mul_sm(t_smag x, t_smag y);
        t_smag r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic t_smag add_sm(t_smag x, t_smag y);
        t_smag r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag; r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag; r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag; r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_smag flip(t_smag x);
        x.neg = !x.neg && x.mag != 0;
        return x;
    endfunction

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        while (a != 0 && b != 0) begin
            if (a < b) b = b % a;
            else a = a % b;
        end
        return (a == 0) ? b : a;
    endfunction

    function automatic t_fraction_result compute_fraction(t_opcode op,
                                                          logic [127:0] d);
        t_fraction_result r;
        t_smag an, ad, bn, bd, n, dn, diff;
        logic [63:0] g;
        logic [63:0] lim;
        an = to_smag(d[31:0]);  ad = to_smag(d[63:32]);
        bn = to_smag(d[95:64]); bd = to_smag(d[127:96]);
        lim = 64'h7FFF_FFFF;
        r = '0;
        if (op > OP_CMP) return r;
        if (ad.mag == 0 || (op != OP_NEG && bd.mag == 0) ||
            (op == OP_DIV && bn.mag == 0)) begin
            r.st = ST_DIV0;
            return r;
        end
        if (op == OP_CMP) begin
            diff = add_sm(mul_sm(an, bd), mul_sm(flip(bn), ad));
            if (diff.mag == 0) r.eq = 1'b1;
            else if (diff.neg != (ad.neg != bd.neg)) r.lt = 1'b1;
            else r.gt = 1'b1;
            return r;
        end
        case (op)
            OP_ADD: begin
                n = add_sm(mul_sm(an, bd), mul_sm(bn, ad)); dn = mul_sm(ad, bd);
            end
            OP_SUB: begin
                n = add_sm(mul_sm(an, bd), mul_sm(flip(bn), ad));
                dn = mul_sm(ad, bd);
            end
            OP_MUL: begin
                n = mul_sm(an, bn); dn = mul_sm(ad, bd);
            end
            OP_DIV: begin
                n = mul_sm(an, bd); dn = mul_sm(ad, bn);
            end
            default: begin
                n = flip(an); dn = ad;
            end
        endcase
        if (dn.neg) n = flip(n);
        g = gcd64(n.mag, dn.mag);
        if (g == 0) g = 1;
        n.mag = n.mag / g;
        dn.mag = dn.mag / g;
        if (dn.mag > lim || (n.neg ? n.mag > lim + 1 : n.mag > lim)) begin
            r.st = ST_OVF;
            return r;
        end
        r.num = n.neg ? 32'(-n.mag) : n.mag[31:0];
        r.den = dn.mag[30:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, o_results);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_results = 0;
    end

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        t_fraction_result want, got;
        if (i_rst_n && s_valid && s_ready)
            result_q.push_back(compute_fraction(s_user, s_data));
        if (i_rst_n && m_valid && m_ready) begin
            got = {m_data[31:0], m_data[62:32], m_data[63], m_data[64], m_data[65],
                   m_user};
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(got), 0);
            end else begin
                want = result_q.pop_front();
                if (got.num != want.num) report_mismatch("res_num", got.num, want.num);
                if (got.den != want.den) report_mismatch("res_den", got.den, want.den);
                if (got.lt != want.lt) report_mismatch("is_less", got.lt, want.lt);
                if (got.eq != want.eq) report_mismatch("is_equal", got.eq, want.eq);
                if (got.gt != want.gt) report_mismatch("is_greater", got.gt, want.gt);
                if (got.st != want.st) report_mismatch("status", got.st, want.st);
                if (m_data[71:66] != 0) report_mismatch("pad", m_data[71:66], 0);
            end
            o_results++;
        end
    end
endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int RANDOM_REQUESTS = 1030;
    localparam int STALL_LIMIT     = 20000;

    // opcodes with no operation behind them
    localparam t_opcode OP_SPARE_LO = 3'd6;
    localparam t_opcode OP_SPARE_HI = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    t_opcode               s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    t_status               m_axis_tuser;

    int fail_count;
    int pending;
    int results;
    int idle_cycles;
    int requests_sent;
    bit calm_stretch;

    rational_arith_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .s_data       (s_axis_tdata),
        .s_user       (s_axis_tuser),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_data       (m_axis_tdata),
        .m_user       (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Drop ready about 23% of the time, except during the calm stretch.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= calm_stretch ? 1'b1 : ($urandom_range(99) >= 23);
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress, %0d results pending", pending);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Pick an operand value, biased toward extremes and small numbers so
    // the reduction and overflow paths get exercised.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return 32'($signed($urandom_range(40)) - 20);
            6: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // Hold one request until the block takes it, then advance.
    task automatic send_request(t_opcode op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {bd, bn, ad, an};
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_gap();
        if (!calm_stretch && $urandom_range(99) < 23) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom(), $urandom(), $urandom(), $urandom()};
            repeat ($urandom_range(3) + 1) @(posedge i_clk);
        end
    endtask

    initial begin
        t_opcode op;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        calm_stretch  = 1'b0;
        requests_sent = 0;
        i_rst_n       = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each operation, zero results, divide by zero, overflow,
        // compare outcomes and the unused opcodes.
        send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_request(OP_MUL, -32'sd3, 32'd4, 32'd8, -32'sd9);
        send_request(OP_DIV, 32'd5, 32'd7, -32'sd10, 32'd21);
        send_request(OP_NEG, 32'd6, -32'sd4, 32'd0, 32'd0);
        send_request(OP_NEG, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_request(OP_NEG, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
        send_request(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
        send_request(OP_CMP, 32'd2, 32'd4, -32'sd1, -32'sd2);
        send_request(OP_CMP, -32'sd1, 32'd2, -32'sd2, 32'd3);
        send_request(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_request(OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
        send_request(OP_DIV, 32'd1, 32'd1, 32'd0, 32'd1);
        send_request(OP_NEG, 32'd1, 32'd0, 32'd1, 32'd1);
        send_request(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000);
        send_request(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000);
        send_request(OP_ADD, 32'd0, -32'sd5, 32'd0, 32'd7);
        send_request(OP_SPARE_LO, 32'd1, 32'd1, 32'd1, 32'd1);
        send_request(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);

        // Random part, with a calm stretch in the middle.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            calm_stretch = (i >= 400 && i < 550);
            op = ($urandom_range(19) == 0)
                 ? t_opcode'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                 : t_opcode'($urandom_range(OP_CMP));
            send_gap();
            send_request(op, pick_value(), pick_value(), pick_value(), pick_value());
        end
        calm_stretch = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("run: %0d requests over all six operations and unused codes, %0d results",
                 requests_sent, results);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rational_arith_unit.sv
hdl/rau_checker.sv
test/tb_checker.sv
test/tb_top.sv
